@@ src/rvdec_pkg.sv @@
// rvdec_pkg: shared types and constants for the rv64i instruction decoder
// opcode, funct7 and immediate codes, mnemonic numbering and the result struct
// no dependencies
`default_nettype none

package rvdec_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CODE_W = 6;

  // major opcodes, bits 6:0
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_REG    = 7'b0110011;
  localparam logic [6:0] OPC_FENCE  = 7'b0001111;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
  localparam logic [6:0] OPC_IMM32  = 7'b0011011;
  localparam logic [6:0] OPC_REG32  = 7'b0111011;

  localparam logic [6:0]  F7_BASE  = 7'b0000000;
  localparam logic [6:0]  F7_ALT   = 7'b0100000;
  localparam logic [5:0]  SHT_BASE = 6'b000000;
  localparam logic [5:0]  SHT_ALT  = 6'b010000;
  localparam logic [11:0] IMM_ECALL  = 12'h000;
  localparam logic [11:0] IMM_EBREAK = 12'h001;
  localparam logic [11:0] IMM_MRET   = 12'b001100000010;

  // funct3 codes
  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  typedef enum logic [CODE_W-1:0] {
    MN_LUI    = 6'd0,  MN_AUIPC  = 6'd1,  MN_JAL    = 6'd2,  MN_JALR   = 6'd3,
    MN_BEQ    = 6'd4,  MN_BNE    = 6'd5,  MN_BLT    = 6'd6,  MN_BGE    = 6'd7,
    MN_BLTU   = 6'd8,  MN_BGEU   = 6'd9,  MN_LB     = 6'd10, MN_LH     = 6'd11,
    MN_LW     = 6'd12, MN_LBU    = 6'd13, MN_LHU    = 6'd14, MN_LWU    = 6'd15,
    MN_LD     = 6'd16, MN_SB     = 6'd17, MN_SH     = 6'd18, MN_SW     = 6'd19,
    MN_SD     = 6'd20, MN_ADDI   = 6'd21, MN_SLTI   = 6'd22, MN_SLTIU  = 6'd23,
    MN_XORI   = 6'd24, MN_ORI    = 6'd25, MN_ANDI   = 6'd26, MN_SLLI   = 6'd27,
    MN_SRLI   = 6'd28, MN_SRAI   = 6'd29, MN_ADD    = 6'd30, MN_SUB    = 6'd31,
    MN_SLL    = 6'd32, MN_SLT    = 6'd33, MN_SLTU   = 6'd34, MN_XOR    = 6'd35,
    MN_SRL    = 6'd36, MN_SRA    = 6'd37, MN_OR     = 6'd38, MN_AND    = 6'd39,
    MN_FENCE  = 6'd40, MN_ECALL  = 6'd41, MN_EBREAK = 6'd42, MN_MRET   = 6'd43,
    MN_CSRRW  = 6'd44, MN_CSRRS  = 6'd45, MN_CSRRC  = 6'd46, MN_CSRRWI = 6'd47,
    MN_CSRRSI = 6'd48, MN_CSRRCI = 6'd49, MN_ADDIW  = 6'd50, MN_SLLIW  = 6'd51,
    MN_SRLIW  = 6'd52, MN_SRAIW  = 6'd53, MN_ADDW   = 6'd54, MN_SUBW   = 6'd55,
    MN_SLLW   = 6'd56, MN_SRLW   = 6'd57, MN_SRAW   = 6'd58
  } mnemonic_t;

  typedef struct packed {
    mnemonic_t code;
    logic      illegal;
  } dec_result_t;

endpackage

`default_nettype wire

@@ src/rvdec_classify.sv @@
// rvdec_classify: combinational decode of one instruction word into a mnemonic
// depends on rvdec_pkg
`default_nettype none

module rvdec_classify (
  input  wire logic [rvdec_pkg::WORD_W-1:0] word,
  output rvdec_pkg::dec_result_t            result
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [5:0]  sht;
  logic [11:0] imm;
  rvdec_pkg::mnemonic_t code;
  logic        bad;

  assign opc = word[6:0];
  assign f3  = word[14:12];
  assign f7  = word[31:25];
  assign sht = word[31:26];
  assign imm = word[31:20];

  always_comb begin
    code = rvdec_pkg::MN_LUI;
    bad  = 1'b0;
    unique case (opc)
      rvdec_pkg::OPC_LUI:   code = rvdec_pkg::MN_LUI;
      rvdec_pkg::OPC_AUIPC: code = rvdec_pkg::MN_AUIPC;
      rvdec_pkg::OPC_JAL:   code = rvdec_pkg::MN_JAL;
      rvdec_pkg::OPC_JALR:  code = rvdec_pkg::MN_JALR;
      rvdec_pkg::OPC_FENCE: code = rvdec_pkg::MN_FENCE;
      rvdec_pkg::OPC_BRANCH: begin
        unique case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_BEQ;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_BNE;
          rvdec_pkg::F3_4: code = rvdec_pkg::MN_BLT;
          rvdec_pkg::F3_5: code = rvdec_pkg::MN_BGE;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_BLTU;
          rvdec_pkg::F3_7: code = rvdec_pkg::MN_BGEU;
          default:         bad  = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_LOAD: begin
        unique case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_LB;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_LH;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_LW;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_LD;
          rvdec_pkg::F3_4: code = rvdec_pkg::MN_LBU;
          rvdec_pkg::F3_5: code = rvdec_pkg::MN_LHU;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_LWU;
          default:         bad  = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_STORE: begin
        unique case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_SB;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SH;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_SW;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_SD;
          default:         bad  = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_IMM: begin
        unique case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_ADDI;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SLLI;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_SLTI;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_SLTIU;
          rvdec_pkg::F3_4: code = rvdec_pkg::MN_XORI;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_ORI;
          rvdec_pkg::F3_7: code = rvdec_pkg::MN_ANDI;
          default: begin
            // 64-bit shifts: only bits 31:26 are compared
            if (sht == rvdec_pkg::SHT_BASE)     code = rvdec_pkg::MN_SRLI;
            else if (sht == rvdec_pkg::SHT_ALT) code = rvdec_pkg::MN_SRAI;
            else                                bad  = 1'b1;
          end
        endcase
      end
      rvdec_pkg::OPC_REG: begin
        // funct7 is only looked at for add/sub and srl/sra
        unique case (f3)
          rvdec_pkg::F3_0: begin
            if (f7 == rvdec_pkg::F7_BASE)     code = rvdec_pkg::MN_ADD;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SUB;
            else                              bad  = 1'b1;
          end
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SLL;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_SLT;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_SLTU;
          rvdec_pkg::F3_4: code = rvdec_pkg::MN_XOR;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_OR;
          rvdec_pkg::F3_7: code = rvdec_pkg::MN_AND;
          default: begin
            if (f7 == rvdec_pkg::F7_BASE)     code = rvdec_pkg::MN_SRL;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SRA;
            else                              bad  = 1'b1;
          end
        endcase
      end
      rvdec_pkg::OPC_SYSTEM: begin
        unique case (f3)
          rvdec_pkg::F3_0: begin
            // rs1 and rd are not checked here
            if (imm == rvdec_pkg::IMM_ECALL)       code = rvdec_pkg::MN_ECALL;
            else if (imm == rvdec_pkg::IMM_EBREAK) code = rvdec_pkg::MN_EBREAK;
            else if (imm == rvdec_pkg::IMM_MRET)   code = rvdec_pkg::MN_MRET;
            else                                   bad  = 1'b1;
          end
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_CSRRW;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_CSRRS;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_CSRRC;
          rvdec_pkg::F3_5: code = rvdec_pkg::MN_CSRRWI;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_CSRRSI;
          rvdec_pkg::F3_7: code = rvdec_pkg::MN_CSRRCI;
          default:         bad  = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_IMM32: begin
        unique case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_ADDIW;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SLLIW;
          rvdec_pkg::F3_5: begin
            if (f7 == rvdec_pkg::F7_BASE)     code = rvdec_pkg::MN_SRLIW;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SRAIW;
            else                              bad  = 1'b1;
          end
          default:         bad  = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_REG32: begin
        unique case (f3)
          rvdec_pkg::F3_0: begin
            if (f7 == rvdec_pkg::F7_BASE)     code = rvdec_pkg::MN_ADDW;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SUBW;
            else                              bad  = 1'b1;
          end
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SLLW;
          rvdec_pkg::F3_5: begin
            if (f7 == rvdec_pkg::F7_BASE)     code = rvdec_pkg::MN_SRLW;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SRAW;
            else                              bad  = 1'b1;
          end
          default:         bad  = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase

    // an unrecognised word reports code zero
    if (bad) code = rvdec_pkg::MN_LUI;
  end

  assign result.code    = code;
  assign result.illegal = bad;

endmodule

`default_nettype wire

@@ src/rv64i_instruction_decoder.sv @@
// rv64i_instruction_decoder: an accepted word passes the input register, then the result register, to the result strobe
// throughput one word per cycle; busy is never raised, the decode between the
// input register and the result register is a single combinational pass
// the receiver cannot stall: each result shows for one cycle under out_valid
// synchronous active-low reset clears both valid flags; no words are lost after reset
// depends on rvdec_pkg and rvdec_classify
`default_nettype none

module rv64i_instruction_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [rvdec_pkg::WORD_W-1:0] in_instr_word,
  output logic                              out_valid,
  output logic [rvdec_pkg::CODE_W-1:0]      out_mnemonic_code,
  output logic                              out_illegal
);

  logic                         in_valid_r;
  logic [rvdec_pkg::WORD_W-1:0] in_word_r;
  rvdec_pkg::dec_result_t       dec_res;
  logic                         out_valid_r;
  rvdec_pkg::dec_result_t       res_r;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_word_r <= in_instr_word;
    end
  end

  rvdec_classify u_classify (
    .word   (in_word_r),
    .result (dec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      res_r <= dec_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mnemonic_code = res_r.code;
  assign out_illegal       = res_r.illegal;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench for rv64i_instruction_decoder: directed and random instruction words with idle bursts
// an in-line decoder predicts code and illegal flag per word, results are checked in order
// depends on rvdec_pkg and the decoder rtl
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RANDOM_WORDS = 725;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned QUIET_LIMIT  = 200;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum logic [1:0] {ST_WORD, ST_GAP, ST_DRAIN} stim_kind_t;

  typedef struct {
    stim_kind_t  kind;
    logic [31:0] word;
    int unsigned count;
  } stim_entry_t;

  typedef struct {
    logic [rvdec_pkg::WORD_W-1:0] word;
    rvdec_pkg::dec_result_t       res;
  } decode_entry_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [rvdec_pkg::WORD_W-1:0] in_instr_word = '0;
  logic                         out_valid;
  logic [rvdec_pkg::CODE_W-1:0] out_mnemonic_code;
  logic                         out_illegal;

  stim_entry_t   word_q[$];
  decode_entry_t decode_q[$];
  bit            word_taken = 1'b0;
  int unsigned   err_cnt = 0;
  int unsigned   quiet_cycles = 0;

  rv64i_instruction_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_instr_word     (in_instr_word),
    .out_valid         (out_valid),
    .out_mnemonic_code (out_mnemonic_code),
    .out_illegal       (out_illegal)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rvdec_pkg::dec_result_t decode_word(
    input logic [rvdec_pkg::WORD_W-1:0] w);
    logic [2:0]             f3;
    logic [6:0]             f7;
    logic [11:0]            imm;
    logic [5:0]             sht;
    rvdec_pkg::mnemonic_t   code;
    logic                   known;
    rvdec_pkg::dec_result_t res;
    f3 = w[14:12];
    f7 = w[31:25];
    imm = w[31:20];
    sht = w[31:26];
    code = rvdec_pkg::MN_LUI;
    known = 1'b1;
    case (w[6:0])
      rvdec_pkg::OPC_LUI:   code = rvdec_pkg::MN_LUI;
      rvdec_pkg::OPC_AUIPC: code = rvdec_pkg::MN_AUIPC;
      rvdec_pkg::OPC_JAL:   code = rvdec_pkg::MN_JAL;
      rvdec_pkg::OPC_JALR:  code = rvdec_pkg::MN_JALR;
      rvdec_pkg::OPC_FENCE: code = rvdec_pkg::MN_FENCE;
      rvdec_pkg::OPC_BRANCH: begin
        case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_BEQ;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_BNE;
          rvdec_pkg::F3_4: code = rvdec_pkg::MN_BLT;
          rvdec_pkg::F3_5: code = rvdec_pkg::MN_BGE;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_BLTU;
          rvdec_pkg::F3_7: code = rvdec_pkg::MN_BGEU;
          default:         known = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_LOAD: begin
        case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_LB;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_LH;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_LW;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_LD;
          rvdec_pkg::F3_4: code = rvdec_pkg::MN_LBU;
          rvdec_pkg::F3_5: code = rvdec_pkg::MN_LHU;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_LWU;
          default:         known = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_STORE: begin
        case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_SB;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SH;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_SW;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_SD;
          default:         known = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_IMM: begin
        case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_ADDI;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SLLI;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_SLTI;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_SLTIU;
          rvdec_pkg::F3_4: code = rvdec_pkg::MN_XORI;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_ORI;
          rvdec_pkg::F3_7: code = rvdec_pkg::MN_ANDI;
          default: begin
            // shift amount bit 25 is not part of the compare here
            if (sht == rvdec_pkg::SHT_BASE) code = rvdec_pkg::MN_SRLI;
            else if (sht == rvdec_pkg::SHT_ALT) code = rvdec_pkg::MN_SRAI;
            else known = 1'b0;
          end
        endcase
      end
      rvdec_pkg::OPC_REG: begin
        case (f3)
          rvdec_pkg::F3_0: begin
            if (f7 == rvdec_pkg::F7_BASE) code = rvdec_pkg::MN_ADD;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SUB;
            else known = 1'b0;
          end
          rvdec_pkg::F3_5: begin
            if (f7 == rvdec_pkg::F7_BASE) code = rvdec_pkg::MN_SRL;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SRA;
            else known = 1'b0;
          end
          // remaining funct3 values take any funct7
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SLL;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_SLT;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_SLTU;
          rvdec_pkg::F3_4: code = rvdec_pkg::MN_XOR;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_OR;
          default:         code = rvdec_pkg::MN_AND;
        endcase
      end
      rvdec_pkg::OPC_SYSTEM: begin
        case (f3)
          rvdec_pkg::F3_0: begin
            if (imm == rvdec_pkg::IMM_ECALL) code = rvdec_pkg::MN_ECALL;
            else if (imm == rvdec_pkg::IMM_EBREAK) code = rvdec_pkg::MN_EBREAK;
            else if (imm == rvdec_pkg::IMM_MRET) code = rvdec_pkg::MN_MRET;
            else known = 1'b0;
          end
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_CSRRW;
          rvdec_pkg::F3_2: code = rvdec_pkg::MN_CSRRS;
          rvdec_pkg::F3_3: code = rvdec_pkg::MN_CSRRC;
          rvdec_pkg::F3_5: code = rvdec_pkg::MN_CSRRWI;
          rvdec_pkg::F3_6: code = rvdec_pkg::MN_CSRRSI;
          rvdec_pkg::F3_7: code = rvdec_pkg::MN_CSRRCI;
          default:         known = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_IMM32: begin
        case (f3)
          rvdec_pkg::F3_0: code = rvdec_pkg::MN_ADDIW;
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SLLIW;
          rvdec_pkg::F3_5: begin
            if (f7 == rvdec_pkg::F7_BASE) code = rvdec_pkg::MN_SRLIW;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SRAIW;
            else known = 1'b0;
          end
          default: known = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_REG32: begin
        case (f3)
          rvdec_pkg::F3_0: begin
            if (f7 == rvdec_pkg::F7_BASE) code = rvdec_pkg::MN_ADDW;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SUBW;
            else known = 1'b0;
          end
          rvdec_pkg::F3_1: code = rvdec_pkg::MN_SLLW;
          rvdec_pkg::F3_5: begin
            if (f7 == rvdec_pkg::F7_BASE) code = rvdec_pkg::MN_SRLW;
            else if (f7 == rvdec_pkg::F7_ALT) code = rvdec_pkg::MN_SRAW;
            else known = 1'b0;
          end
          default: known = 1'b0;
        endcase
      end
      default: known = 1'b0;
    endcase
    res.code = known ? code : rvdec_pkg::MN_LUI;
    res.illegal = ~known;
    return res;
  endfunction

  function automatic logic [6:0] opcode_at(input int unsigned idx);
    case (idx)
      0:       return rvdec_pkg::OPC_LUI;
      1:       return rvdec_pkg::OPC_AUIPC;
      2:       return rvdec_pkg::OPC_JAL;
      3:       return rvdec_pkg::OPC_JALR;
      4:       return rvdec_pkg::OPC_BRANCH;
      5:       return rvdec_pkg::OPC_LOAD;
      6:       return rvdec_pkg::OPC_STORE;
      7:       return rvdec_pkg::OPC_IMM;
      8:       return rvdec_pkg::OPC_REG;
      9:       return rvdec_pkg::OPC_FENCE;
      10:      return rvdec_pkg::OPC_SYSTEM;
      11:      return rvdec_pkg::OPC_IMM32;
      default: return rvdec_pkg::OPC_REG32;
    endcase
  endfunction

  // random register and immediate bits around the given funct7, funct3 and opcode
  function automatic logic [31:0] pack_word(input logic [6:0] f7, input logic [2:0] f3,
                                            input logic [6:0] opc);
    logic [31:0] w;
    w = $urandom();
    w[31:25] = f7;
    w[14:12] = f3;
    w[6:0] = opc;
    return w;
  endfunction

  function automatic logic [31:0] make_word();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(0, 99) < 12) return w;
    w[6:0] = opcode_at($urandom_range(0, 12));
    case ($urandom_range(0, 4))
      0: w[31:25] = rvdec_pkg::F7_BASE;
      1: w[31:25] = rvdec_pkg::F7_ALT;
      2: w[31:26] = $urandom_range(0, 1) ? rvdec_pkg::SHT_ALT : rvdec_pkg::SHT_BASE;
      default: ;
    endcase
    if (w[6:0] == rvdec_pkg::OPC_SYSTEM && $urandom_range(0, 2) == 0) begin
      w[14:12] = rvdec_pkg::F3_0;
      case ($urandom_range(0, 2))
        0:       w[31:20] = rvdec_pkg::IMM_ECALL;
        1:       w[31:20] = rvdec_pkg::IMM_EBREAK;
        default: w[31:20] = rvdec_pkg::IMM_MRET;
      endcase
    end
    return w;
  endfunction

  task automatic push_word(input logic [31:0] w);
    stim_entry_t e;
    e.kind = ST_WORD;
    e.word = w;
    e.count = 0;
    word_q.push_back(e);
  endtask

  task automatic push_gap(input int unsigned n);
    stim_entry_t e;
    e.kind = ST_GAP;
    e.word = '0;
    e.count = n;
    word_q.push_back(e);
  endtask

  task automatic push_drain();
    stim_entry_t e;
    e.kind = ST_DRAIN;
    e.word = '0;
    e.count = 0;
    word_q.push_back(e);
  endtask

  // driver: a presented word is held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
    end else if (word_q.size() == 0) begin
      start <= 1'b0;
    end else begin
      case (word_q[0].kind)
        ST_GAP: begin
          start <= 1'b0;
          in_instr_word <= $urandom();
          if (word_q[0].count <= 1) void'(word_q.pop_front());
          else word_q[0].count--;
        end
        ST_DRAIN: begin
          start <= 1'b0;
          if (decode_q.size() == 0) void'(word_q.pop_front());
        end
        default: begin
          start <= 1'b1;
          in_instr_word <= word_q[0].word;
          void'(word_q.pop_front());
        end
      endcase
    end
  end

  // monitor: check the result word first, then log the accepted instruction word
  always @(posedge clk) begin
    decode_entry_t exp_e;
    if (rst_n && out_valid) begin
      if (decode_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected result: code %0d illegal %0b", out_mnemonic_code, out_illegal);
      end else begin
        exp_e = decode_q.pop_front();
        if (out_mnemonic_code !== exp_e.res.code || out_illegal !== exp_e.res.illegal) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("mismatch on word %h: expected code %0d illegal %0b, got code %0d illegal %0b",
                     exp_e.word, exp_e.res.code, exp_e.res.illegal,
                     out_mnemonic_code, out_illegal);
        end
      end
    end
    word_taken = rst_n && start && !busy;
    if (word_taken) begin
      exp_e.word = in_instr_word;
      exp_e.res = decode_word(in_instr_word);
      decode_q.push_back(exp_e);
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned idx;
    // extremes and the odd corners of the decode
    push_word(32'h0000_0000);
    push_word(32'hFFFF_FFFF);
    push_word({25'h1FF_FFFF, rvdec_pkg::OPC_LUI});
    push_word({25'h1FF_FFFF, rvdec_pkg::OPC_JAL});
    push_word({rvdec_pkg::IMM_ECALL, 5'd0, rvdec_pkg::F3_0, 5'd0, rvdec_pkg::OPC_SYSTEM});
    push_word({rvdec_pkg::IMM_EBREAK, 5'd9, rvdec_pkg::F3_0, 5'd3, rvdec_pkg::OPC_SYSTEM});
    push_word({rvdec_pkg::IMM_MRET, 5'd31, rvdec_pkg::F3_0, 5'd31, rvdec_pkg::OPC_SYSTEM});
    push_word({rvdec_pkg::IMM_MRET ^ 12'h001, 5'd0, rvdec_pkg::F3_0, 5'd0,
               rvdec_pkg::OPC_SYSTEM});
    push_word(pack_word(7'h3C, rvdec_pkg::F3_4, rvdec_pkg::OPC_SYSTEM));
    push_word({25'h1FF_FFFF, rvdec_pkg::OPC_FENCE});
    push_word(pack_word(7'h7F, rvdec_pkg::F3_7, rvdec_pkg::OPC_JALR));
    push_word(pack_word(7'h7F, rvdec_pkg::F3_1, rvdec_pkg::OPC_IMM));
    push_word(pack_word(rvdec_pkg::F7_ALT | 7'h01, rvdec_pkg::F3_5, rvdec_pkg::OPC_IMM));
    push_word(pack_word(7'h01, rvdec_pkg::F3_5, rvdec_pkg::OPC_IMM));
    push_word(pack_word(7'h60, rvdec_pkg::F3_5, rvdec_pkg::OPC_IMM));
    push_word(pack_word(7'h55, rvdec_pkg::F3_1, rvdec_pkg::OPC_REG));
    push_word(pack_word(rvdec_pkg::F7_ALT, rvdec_pkg::F3_0, rvdec_pkg::OPC_REG));
    push_word(pack_word(7'h21, rvdec_pkg::F3_5, rvdec_pkg::OPC_REG));
    push_word(pack_word(7'h7F, rvdec_pkg::F3_1, rvdec_pkg::OPC_IMM32));
    push_word(pack_word(7'h21, rvdec_pkg::F3_5, rvdec_pkg::OPC_IMM32));
    push_word(pack_word(rvdec_pkg::F7_ALT, rvdec_pkg::F3_0, rvdec_pkg::OPC_REG32));
    push_word(pack_word(rvdec_pkg::F7_BASE, rvdec_pkg::F3_2, rvdec_pkg::OPC_BRANCH));
    push_word(pack_word(7'h7F, rvdec_pkg::F3_7, rvdec_pkg::OPC_LOAD));
    push_word(pack_word(rvdec_pkg::F7_BASE, rvdec_pkg::F3_4, rvdec_pkg::OPC_STORE));
    push_word(pack_word(rvdec_pkg::F7_BASE, rvdec_pkg::F3_2, rvdec_pkg::OPC_REG32));
    push_drain();
    for (idx = 0; idx < RANDOM_WORDS; idx++) begin
      push_word(make_word());
      if (idx == RANDOM_WORDS / 2) push_drain();
      if (idx + CALM_TAIL < RANDOM_WORDS && $urandom_range(0, 5) == 0)
        push_gap($urandom_range(1, 17));
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (word_q.size() != 0 || start) @(posedge clk);
    while (decode_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
